### hw/rtl/rrrp_pkg.sv
// Shared constants, types and tables for the RRRP arm Jacobian block.
// No dependencies.
`default_nettype none
package rrrp_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 12;
    localparam int ATAN_LEN      = 24;
    localparam int N_STG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    localparam int ANG_W = 16;
    localparam int LEN_W = 16;
    localparam int ENT_W = 20;
    localparam int ROW_W = 3;
    localparam int OUT_FRAC = 12;

    // CORDIC datapath: x, y in Q4.30 (34 bits), z as 33-bit binary angle
    localparam int XW = 34;
    localparam int ZW = 33;
    localparam logic signed [XW-1:0] INV_GAIN = XW'(32'h26DD3B6A);

    // trig values, products and sums
    localparam int TW = FRAC_BITS + 2;
    localparam int PW = LEN_W + TW;
    localparam int RW = PW + 1;
    localparam int MW = TW + 1 + RW;

    localparam logic [ROW_W-1:0] ROW_FIRST = 3'd0;
    localparam logic [ROW_W-1:0] ROW_LAST  = 3'd5;

    localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic signed [TW-1:0] t_trig;
    typedef logic signed [MW-1:0] t_prod;
    typedef logic signed [ENT_W-1:0] t_ent;
endpackage
`default_nettype wire

### hw/rtl/rrrp_if.sv
// Valid/ready channel interfaces for joint samples and Jacobian rows.
// Depends on rrrp_pkg for field widths.
`default_nettype none
interface rrrp_in_if;
    logic valid;
    logic ready;
    logic signed [rrrp_pkg::ANG_W-1:0] base_angle;
    logic signed [rrrp_pkg::ANG_W-1:0] shoulder_angle;
    logic signed [rrrp_pkg::ANG_W-1:0] elbow_angle;
    logic signed [rrrp_pkg::LEN_W-1:0] extension;
    modport source(output valid, base_angle, shoulder_angle, elbow_angle, extension,
                   input ready);
    modport sink(input valid, base_angle, shoulder_angle, elbow_angle, extension,
                 output ready);
endinterface

interface rrrp_out_if;
    logic valid;
    logic ready;
    logic [rrrp_pkg::ROW_W-1:0] row_index;
    logic signed [rrrp_pkg::ENT_W-1:0] entry_col0;
    logic signed [rrrp_pkg::ENT_W-1:0] entry_col1;
    logic signed [rrrp_pkg::ENT_W-1:0] entry_col2;
    logic signed [rrrp_pkg::ENT_W-1:0] entry_col3;
    logic last_row;
    modport source(output valid, row_index, entry_col0, entry_col1, entry_col2,
                   entry_col3, last_row, input ready);
    modport sink(input valid, row_index, entry_col0, entry_col1, entry_col2,
                 entry_col3, last_row, output ready);
endinterface
`default_nettype wire

### hw/rtl/rrrp_arm_jacobian_top.sv
// RRRP arm geometric Jacobian: pipelined CORDIC, multiply stages, row serializer.
// Depends on rrrp_pkg and the channel interfaces in rrrp_if.sv.
//
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   base/shoulder/elbow angle, extension
//  o_out     out  valid/ready   row_index, entry_col0..3, last_row
//  i_cfg     in   write enable  link_length (Q4.12)
//
// The output emits one row per cycle while o_out.ready is high, six rows per item.
// Path to row 0: input, CORDIC, rounding, products, sums, products, serializer.
// Reset clears valid bits, the row counter and link_length.
// The pipeline holds while its last stage has an item the serializer cannot take.
`default_nettype none
module rrrp_arm_jacobian_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rrrp_pkg::LEN_W-1:0]    i_cfg_data,
    rrrp_in_if.sink                            i_in,
    rrrp_out_if.source                         o_out
);
    import rrrp_pkg::*;

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [XW-1:0] RND = XW'(1) <<< (SH - 1);
    localparam logic signed [XW-1:0] ONE = XW'(1) <<< FRAC_BITS;

    function automatic t_trig trig_out(input logic signed [XW-1:0] v, input logic fl);
        logic signed [XW-1:0] v2;
        logic signed [XW-1:0] v3;
        v2 = fl ? -v : v;
        v3 = (v2 + RND) >>> SH;
        if (v3 > ONE) v3 = ONE;
        if (v3 < -ONE) v3 = -ONE;
        return v3[TW-1:0];
    endfunction

    function automatic t_ent to_out(input t_prod v, input int frac);
        logic signed [MW:0] t;
        if (frac > OUT_FRAC) begin
            t = ((MW+1)'(v) + ((MW+1)'(1) <<< (frac - OUT_FRAC - 1))) >>> (frac - OUT_FRAC);
        end else begin
            t = (MW+1)'(v) <<< (OUT_FRAC - frac);
        end
        return t[ENT_W-1:0];
    endfunction

    logic signed [LEN_W-1:0] r_link;
    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else if (i_cfg_we) begin
            r_link <= i_cfg_data;
        end
    end

    // input stage
    logic                     r_p_v;
    logic [ANG_W-1:0]         r_p_ang [3];
    logic signed [LEN_W-1:0]  r_p_q4;

    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ang[0] <= i_in.base_angle;
            r_p_ang[1] <= i_in.shoulder_angle;
            r_p_ang[2] <= i_in.shoulder_angle + i_in.elbow_angle;
            r_p_q4     <= i_in.extension;
        end
    end

    // CORDIC stages, three units side by side
    logic                    r_c_v  [N_STG];
    logic signed [XW-1:0]    r_c_x  [N_STG][3];
    logic signed [XW-1:0]    r_c_y  [N_STG][3];
    logic signed [ZW-1:0]    r_c_z  [N_STG][3];
    logic                    r_c_fl [N_STG][3];
    logic signed [LEN_W-1:0] r_c_q4 [N_STG];

    for (genvar g = 0; g < N_STG; g++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_v[g] <= 1'b0;
            end else if (en) begin
                r_c_v[g] <= (g == 0) ? r_p_v : r_c_v[(g == 0) ? 0 : g - 1];
            end
        end
        if (g == 0) begin : g_q0
            always_ff @(posedge i_clk) begin
                if (en) r_c_q4[g] <= r_p_q4;
            end
        end else begin : g_qn
            always_ff @(posedge i_clk) begin
                if (en) r_c_q4[g] <= r_c_q4[g-1];
            end
        end
        for (genvar u = 0; u < 3; u++) begin : g_unit
            logic signed [XW-1:0] x_i, y_i, n_x, n_y;
            logic signed [ZW-1:0] z_i, n_z;
            logic                 fl_i;
            logic signed [ZW-1:0] at;
            if (g == 0) begin : g_init
                // turn angles in the left half-plane by pi, negate at the end
                always_comb begin
                    fl_i = r_p_ang[u][15] ^ r_p_ang[u][14];
                    x_i  = INV_GAIN;
                    y_i  = '0;
                    z_i  = ZW'($signed({r_p_ang[u][15] ^ fl_i, r_p_ang[u][14:0], 16'b0}));
                end
            end else begin : g_chain
                always_comb begin
                    fl_i = r_c_fl[g-1][u];
                    x_i  = r_c_x[g-1][u];
                    y_i  = r_c_y[g-1][u];
                    z_i  = r_c_z[g-1][u];
                end
            end
            assign at = $signed({1'b0, ATAN_TURN[g]});
            always_comb begin
                if (!z_i[ZW-1]) begin
                    n_x = x_i - (y_i >>> g);
                    n_y = y_i + (x_i >>> g);
                    n_z = z_i - at;
                end else begin
                    n_x = x_i + (y_i >>> g);
                    n_y = y_i - (x_i >>> g);
                    n_z = z_i + at;
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_c_x[g][u]  <= n_x;
                    r_c_y[g][u]  <= n_y;
                    r_c_z[g][u]  <= n_z;
                    r_c_fl[g][u] <= fl_i;
                end
            end
        end
    end

    // rounding stage
    logic r_r_v;
    t_trig r_s1, r_c1, r_s2, r_c2, r_s23, r_c23;
    logic signed [LEN_W-1:0] r_r_q4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (en) begin
            r_r_v <= r_c_v[N_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1   <= trig_out(r_c_x[N_STG-1][0], r_c_fl[N_STG-1][0]);
            r_s1   <= trig_out(r_c_y[N_STG-1][0], r_c_fl[N_STG-1][0]);
            r_c2   <= trig_out(r_c_x[N_STG-1][1], r_c_fl[N_STG-1][1]);
            r_s2   <= trig_out(r_c_y[N_STG-1][1], r_c_fl[N_STG-1][1]);
            r_c23  <= trig_out(r_c_x[N_STG-1][2], r_c_fl[N_STG-1][2]);
            r_s23  <= trig_out(r_c_y[N_STG-1][2], r_c_fl[N_STG-1][2]);
            r_r_q4 <= r_c_q4[N_STG-1];
        end
    end

    // first products
    logic r_m1_v;
    logic signed [PW-1:0] r_a2c2, r_q4s23, r_a2s2, r_q4c23;
    t_trig r_m1_s1, r_m1_c1, r_m1_s23, r_m1_c23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= r_r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a2c2   <= PW'(r_link) * PW'(r_c2);
            r_a2s2   <= PW'(r_link) * PW'(r_s2);
            r_q4s23  <= PW'(r_r_q4) * PW'(r_s23);
            r_q4c23  <= PW'(r_r_q4) * PW'(r_c23);
            r_m1_s1  <= r_s1;
            r_m1_c1  <= r_c1;
            r_m1_s23 <= r_s23;
            r_m1_c23 <= r_c23;
        end
    end

    // sums r and k
    logic r_m2_v;
    logic signed [RW-1:0] r_r, r_k;
    logic signed [PW-1:0] r_m2_q4s23, r_m2_q4c23;
    t_trig r_m2_s1, r_m2_c1, r_m2_s23, r_m2_c23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r        <= RW'(r_a2c2) + RW'(r_q4s23);
            r_k        <= RW'(r_q4c23) - RW'(r_a2s2);
            r_m2_q4s23 <= r_q4s23;
            r_m2_q4c23 <= r_q4c23;
            r_m2_s1    <= r_m1_s1;
            r_m2_c1    <= r_m1_c1;
            r_m2_s23   <= r_m1_s23;
            r_m2_c23   <= r_m1_c23;
        end
    end

    // second products, the pipeline tail
    logic r_m3_v;
    t_prod r_p00, r_p01, r_p02, r_p03, r_p10, r_p11, r_p12, r_p13;
    t_prod r_p21, r_p22, r_p23, r_p31, r_p41;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_v <= 1'b0;
        end else if (en) begin
            r_m3_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p00 <= -MW'(r_m2_s1) * MW'(r_r);
            r_p01 <= MW'(r_m2_c1) * MW'(r_k);
            r_p02 <= MW'(r_m2_c1) * MW'(r_m2_q4c23);
            r_p03 <= MW'(r_m2_c1) * MW'(r_m2_s23);
            r_p10 <= MW'(r_m2_c1) * MW'(r_r);
            r_p11 <= MW'(r_m2_s1) * MW'(r_k);
            r_p12 <= MW'(r_m2_s1) * MW'(r_m2_q4c23);
            r_p13 <= MW'(r_m2_s1) * MW'(r_m2_s23);
            r_p21 <= -MW'(r_r);
            r_p22 <= -MW'(r_m2_q4s23);
            r_p23 <= MW'(r_m2_c23);
            r_p31 <= -MW'(r_m2_s1);
            r_p41 <= MW'(r_m2_c1);
        end
    end

    // row serializer
    logic             r_ovld;
    logic [ROW_W-1:0] r_row;
    t_ent r_e00, r_e01, r_e02, r_e03, r_e10, r_e11, r_e12, r_e13;
    t_ent r_e21, r_e22, r_e23, r_e31, r_e41;
    logic load_ok;
    logic load;

    assign load_ok = !r_ovld || (o_out.ready && (r_row == ROW_LAST));
    assign en      = !r_m3_v || load_ok;
    assign load    = r_m3_v && load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_row  <= ROW_FIRST;
        end else if (load_ok) begin
            r_ovld <= r_m3_v;
            r_row  <= ROW_FIRST;
        end else if (o_out.ready) begin
            r_row <= r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_e00 <= to_out(r_p00, OUT_FRAC + 2 * FRAC_BITS);
            r_e01 <= to_out(r_p01, OUT_FRAC + 2 * FRAC_BITS);
            r_e02 <= to_out(r_p02, OUT_FRAC + 2 * FRAC_BITS);
            r_e03 <= to_out(r_p03, 2 * FRAC_BITS);
            r_e10 <= to_out(r_p10, OUT_FRAC + 2 * FRAC_BITS);
            r_e11 <= to_out(r_p11, OUT_FRAC + 2 * FRAC_BITS);
            r_e12 <= to_out(r_p12, OUT_FRAC + 2 * FRAC_BITS);
            r_e13 <= to_out(r_p13, 2 * FRAC_BITS);
            r_e21 <= to_out(r_p21, OUT_FRAC + FRAC_BITS);
            r_e22 <= to_out(r_p22, OUT_FRAC + FRAC_BITS);
            r_e23 <= to_out(r_p23, FRAC_BITS);
            r_e31 <= to_out(r_p31, FRAC_BITS);
            r_e41 <= to_out(r_p41, FRAC_BITS);
        end
    end

    assign o_out.valid     = r_ovld;
    assign o_out.row_index = r_row;
    assign o_out.last_row  = (r_row == ROW_LAST);

    always_comb begin
        o_out.entry_col0 = '0;
        o_out.entry_col1 = '0;
        o_out.entry_col2 = '0;
        o_out.entry_col3 = '0;
        case (r_row)
            3'd0: begin
                o_out.entry_col0 = r_e00;
                o_out.entry_col1 = r_e01;
                o_out.entry_col2 = r_e02;
                o_out.entry_col3 = r_e03;
            end
            3'd1: begin
                o_out.entry_col0 = r_e10;
                o_out.entry_col1 = r_e11;
                o_out.entry_col2 = r_e12;
                o_out.entry_col3 = r_e13;
            end
            3'd2: begin
                o_out.entry_col1 = r_e21;
                o_out.entry_col2 = r_e22;
                o_out.entry_col3 = r_e23;
            end
            3'd3: begin
                o_out.entry_col1 = r_e31;
                o_out.entry_col2 = r_e31;
            end
            3'd4: begin
                o_out.entry_col1 = r_e41;
                o_out.entry_col2 = r_e41;
            end
            3'd5: begin
                o_out.entry_col0 = ENT_W'(1) <<< OUT_FRAC;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/rrrp_chk.sv
// Port-level checker for the RRRP Jacobian block and its bind to the top level.
// Depends on rrrp_pkg for row constants.
`default_nettype none
module rrrp_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [rrrp_pkg::ROW_W-1:0] i_row_index,
    input wire logic                       i_last_row
);
    import rrrp_pkg::*;

    // a stalled row transaction holds its row number
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_row_index))
        else $error("row changed under stall");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_row == (i_row_index == ROW_LAST)))
        else $error("last_row flag mismatch");

    // rows of one item leave back to back in order
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_row_index != ROW_LAST) |=>
        i_out_valid && (i_row_index == $past(i_row_index) + 3'd1))
        else $error("row sequence broken");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_row_index <= ROW_LAST))
        else $error("row index out of range");
endmodule

bind rrrp_arm_jacobian_top rrrp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_row_index (o_out.row_index),
    .i_last_row  (o_out.last_row)
);
`default_nettype wire

### test/tb_rrrp_arm_jacobian_top.sv
// Self-checking bench for the RRRP arm Jacobian block: random and corner joint samples,
// each predicted row compared field by field. Depends on rrrp_pkg, rrrp_if.sv and the RTL.
`default_nettype none
module tb_rrrp_arm_jacobian_top;
    import rrrp_pkg::*;

    typedef struct packed {
        logic [15:0] q1;
        logic [15:0] q2;
        logic [15:0] q3;
        logic [15:0] q4;
    } t_sample;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ENT_W-1:0] e0;
        logic [ENT_W-1:0] e1;
        logic [ENT_W-1:0] e2;
        logic [ENT_W-1:0] e3;
        logic             last;
    } t_row;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = CORDIC_STAGES + 12;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LEN_W-1:0] i_cfg_data;

    rrrp_in_if  in_ch();
    rrrp_out_if out_ch();

    rrrp_arm_jacobian_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    t_sample     pending_q[$];
    t_row        rows_due_q[$];
    logic [15:0] link_len;
    int          idle_pct;
    int          stall_pct;
    int          mismatch_cnt;
    int          quiet_cycles;
    logic        in_acc;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // round half up, then floor shift
    function automatic longint round_shift(longint v, int sh);
        longint t;
        if (sh <= 0) return v <<< (-sh);
        t = v + (longint'(1) <<< (sh - 1));
        return t >>> sh;
    endfunction

    task automatic cordic_trig(input logic [15:0] ang, output longint s, output longint c);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, dx, dy, one;
        int          sh;
        a    = {ang, 16'h0};
        flip = a[31] ^ a[30];
        x    = 64'h26DD3B6A;
        y    = 0;
        one  = longint'(1) <<< FRAC_BITS;
        sh   = 30 - FRAC_BITS;
        if (flip) a = a + 32'h8000_0000;
        z = longint'($signed(a));
        for (int i = 0; i < N_STG; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TURN[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TURN[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        x = round_shift(x, sh);
        y = round_shift(y, sh);
        if (x > one) x = one;
        if (x < -one) x = -one;
        if (y > one) y = one;
        if (y < -one) y = -one;
        c = x;
        s = y;
    endtask

    task automatic predict_jacobian(input t_sample smp);
        longint s1, c1, s2, c2, s23, c23, r, k, a2, q4;
        longint m[6][4];
        int     fo;
        t_row   rw;
        fo = OUT_FRAC;
        cordic_trig(smp.q1, s1, c1);
        cordic_trig(smp.q2, s2, c2);
        cordic_trig(smp.q2 + smp.q3, s23, c23);
        a2 = longint'($signed(link_len));
        q4 = longint'($signed(smp.q4));
        r = a2 * c2 + q4 * s23;
        k = -a2 * s2 + q4 * c23;
        m[0][0] = round_shift(-s1 * r, fo + 2 * FRAC_BITS - OUT_FRAC);
        m[0][1] = round_shift(c1 * k, fo + 2 * FRAC_BITS - OUT_FRAC);
        m[0][2] = round_shift(c1 * q4 * c23, fo + 2 * FRAC_BITS - OUT_FRAC);
        m[0][3] = round_shift(c1 * s23, 2 * FRAC_BITS - OUT_FRAC);
        m[1][0] = round_shift(c1 * r, fo + 2 * FRAC_BITS - OUT_FRAC);
        m[1][1] = round_shift(s1 * k, fo + 2 * FRAC_BITS - OUT_FRAC);
        m[1][2] = round_shift(s1 * q4 * c23, fo + 2 * FRAC_BITS - OUT_FRAC);
        m[1][3] = round_shift(s1 * s23, 2 * FRAC_BITS - OUT_FRAC);
        m[2][0] = 0;
        m[2][1] = round_shift(-r, fo + FRAC_BITS - OUT_FRAC);
        m[2][2] = round_shift(-q4 * s23, fo + FRAC_BITS - OUT_FRAC);
        m[2][3] = round_shift(c23, FRAC_BITS - OUT_FRAC);
        m[3][0] = 0;
        m[3][1] = round_shift(-s1, FRAC_BITS - OUT_FRAC);
        m[3][2] = m[3][1];
        m[3][3] = 0;
        m[4][0] = 0;
        m[4][1] = round_shift(c1, FRAC_BITS - OUT_FRAC);
        m[4][2] = m[4][1];
        m[4][3] = 0;
        m[5][0] = longint'(1) <<< OUT_FRAC;
        m[5][1] = 0;
        m[5][2] = 0;
        m[5][3] = 0;
        for (int i = 0; i < 6; i++) begin
            rw.row  = ROW_W'(i);
            rw.e0   = m[i][0][ENT_W-1:0];
            rw.e1   = m[i][1][ENT_W-1:0];
            rw.e2   = m[i][2][ENT_W-1:0];
            rw.e3   = m[i][3][ENT_W-1:0];
            rw.last = (rw.row == ROW_LAST);
            rows_due_q.push_back(rw);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_cnt++;
    endtask

    // driver: present the queue head, advance once the last edge took it
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_acc) begin
            if (pending_q.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                in_ch.base_angle     <= pending_q[0].q1;
                in_ch.shoulder_angle <= pending_q[0].q2;
                in_ch.elbow_angle    <= pending_q[0].q3;
                in_ch.extension      <= pending_q[0].q4;
                in_ch.valid          <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= i_rst_n && ($urandom_range(99, 0) >= stall_pct);
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge i_clk) begin
        t_row exp_row;
        logic act;
        act = 1'b0;
        if (i_rst_n) begin
            in_acc <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                predict_jacobian({in_ch.base_angle, in_ch.shoulder_angle,
                                  in_ch.elbow_angle, in_ch.extension});
                void'(pending_q.pop_front());
                act = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                act = 1'b1;
                if (rows_due_q.size() == 0) begin
                    report_mismatch("unexpected row", out_ch.row_index, 0);
                end else begin
                    exp_row = rows_due_q.pop_front();
                    if (out_ch.row_index !== exp_row.row)
                        report_mismatch("row_index", out_ch.row_index, exp_row.row);
                    if (out_ch.entry_col0 !== exp_row.e0)
                        report_mismatch("entry_col0", out_ch.entry_col0, exp_row.e0);
                    if (out_ch.entry_col1 !== exp_row.e1)
                        report_mismatch("entry_col1", out_ch.entry_col1, exp_row.e1);
                    if (out_ch.entry_col2 !== exp_row.e2)
                        report_mismatch("entry_col2", out_ch.entry_col2, exp_row.e2);
                    if (out_ch.entry_col3 !== exp_row.e3)
                        report_mismatch("entry_col3", out_ch.entry_col3, exp_row.e3);
                    if (out_ch.last_row !== exp_row.last)
                        report_mismatch("last_row", out_ch.last_row, exp_row.last);
                end
            end
            quiet_cycles <= act ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic t_sample rand_sample();
        t_sample smp;
        smp.q1 = 16'($urandom);
        smp.q2 = 16'($urandom);
        smp.q3 = 16'($urandom);
        smp.q4 = 16'($urandom);
        return smp;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || rows_due_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_link_length(input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_data <= val;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        link_len = val;
    endtask

    initial begin
        logic [15:0] corners[8];
        logic [15:0] lengths[5];
        corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                    16'hC000, 16'h2000, 16'hFFFF, 16'h0001};
        lengths = '{16'h7FFF, 16'h8000, 16'h1000, 16'hF000, 16'h5A5A};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.base_angle     = '0;
        in_ch.shoulder_angle = '0;
        in_ch.elbow_angle    = '0;
        in_ch.extension      = '0;
        out_ch.ready = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        in_acc       = 1'b0;
        link_len     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset value of a2 is zero: hit corners before any write
        for (int i = 0; i < 8; i++)
            pending_q.push_back('{corners[i], corners[(i + 3) % 8],
                                  corners[(i + 5) % 8], corners[i]});
        wait_drained();

        write_link_length(16'h7FFF);
        // angle sum wraps past one turn
        pending_q.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        pending_q.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
        pending_q.push_back('{16'h4000, 16'h4000, 16'h4000, 16'h7FFF});
        pending_q.push_back('{16'hC000, 16'h8000, 16'h4000, 16'h8000});
        pending_q.push_back('{16'h3FFF, 16'hBFFF, 16'h0001, 16'h8000});
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            write_link_length(lengths[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            for (int i = 0; i < 40; i++) pending_q.push_back(rand_sample());
            wait_drained();
        end
        idle_pct  = 0;
        stall_pct = 0;

        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
hw/rtl/rrrp_pkg.sv
hw/rtl/rrrp_if.sv
hw/rtl/rrrp_arm_jacobian_top.sv
hw/rtl/rrrp_chk.sv
test/tb_rrrp_arm_jacobian_top.sv
